@@ src/chiplet_control_register_bank_unit_assert.svh @@
// Assertion macros used by the register bank RTL.
// Each macro expands to one labeled concurrent assertion that is
// disabled while reset is high.
`ifndef CHIPLET_CONTROL_REGISTER_BANK_UNIT_ASSERT_SVH
`define CHIPLET_CONTROL_REGISTER_BANK_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define CRBU_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("register bank assertion failed");

// Consequent checked in the cycle after the antecedent.
`define CRBU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("register bank assertion failed");

`endif

@@ src/crbu_pkg.sv @@
// ----------------------------------------------------------------------------
// crbu_pkg
// Types and constants of the control register bank: register numbers,
// access codes, status codes and the decode record.
// ----------------------------------------------------------------------------
package crbu_pkg;

   localparam int DATA_WIDTH = 64;
   localparam int REG_NUM_WIDTH = 10;

   // Fixed register numbers.
   localparam logic [REG_NUM_WIDTH-1:0] REG_CONF0      = 10'h008;
   localparam logic [REG_NUM_WIDTH-1:0] REG_CONF0_SET  = 10'h018;
   localparam logic [REG_NUM_WIDTH-1:0] REG_CONF0_CLR  = 10'h028;
   localparam logic [REG_NUM_WIDTH-1:0] REG_CONF1      = 10'h009;
   localparam logic [REG_NUM_WIDTH-1:0] REG_CONF1_SET  = 10'h019;
   localparam logic [REG_NUM_WIDTH-1:0] REG_CONF1_CLR  = 10'h029;
   localparam logic [REG_NUM_WIDTH-1:0] REG_STATUS     = 10'h100;
   localparam logic [REG_NUM_WIDTH-1:0] REG_MASK       = 10'h101;
   localparam logic [REG_NUM_WIDTH-1:0] REG_PROTECT    = 10'h3FE;
   localparam logic [REG_NUM_WIDTH-1:0] REG_LOCK       = 10'h3FF;
   localparam logic [REG_NUM_WIDTH-1:0] SET_ALIAS_BASE = 10'h010;
   localparam logic [REG_NUM_WIDTH-1:0] CLR_ALIAS_BASE = 10'h020;

   localparam logic [DATA_WIDTH-1:0] ALL_ONES = '1;

   // Access kind carried by the request.
   localparam logic OPCODE_READ  = 1'b0;
   localparam logic OPCODE_WRITE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK            = 2'd0,
      STATUS_WRITE_ONLY    = 2'd1,
      STATUS_UNIMPLEMENTED = 2'd2
   } access_status_type;

   typedef enum logic [1:0] {
      KIND_PLAIN = 2'd0,
      KIND_SET   = 2'd1,
      KIND_CLEAR = 2'd2
   } write_kind_type;

   typedef struct packed {
      logic           plain_hit;
      logic           alias_hit;
      write_kind_type kind;
   } decode_type;

   typedef enum logic {
      STATE_IDLE = 1'b0,
      STATE_EXEC = 1'b1
   } state_type;

endpackage

@@ src/chiplet_control_register_bank_unit.sv @@
// ----------------------------------------------------------------------------
// chiplet_control_register_bank_unit
// Bank of 64-bit control registers with set-bit and clear-bit aliases.
// ----------------------------------------------------------------------------
// Usage:
//   A request transfer happens at a rising edge with start high and busy
//   low; it carries the opcode, the register number and the write data.
//   The request is decoded and its storage entry read in the cycle of the
//   transfer. In the following cycle busy is high, the old value is
//   combined with the write data and written back, and the result is
//   registered. The result is on rsp_read_data and rsp_access_status for
//   one cycle with rsp_valid high, out of the result register. No request
//   is taken while busy is high: the read of the storage memory is
//   followed by its write-back, and busy keeps the next read from meeting
//   a write still pending to the same entry.
//   A new request may be presented in the cycle the result is shown.
//   The receiver cannot stall; every result is taken in its cycle.
//   Reset clears the valid bits of the storage, so every register reads
//   as zero until written, and drops any request in progress.
// ----------------------------------------------------------------------------
module chiplet_control_register_bank_unit
   import crbu_pkg::*;
#(
   parameter int CONTROL_WORD_COUNT = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_opcode,
   input  logic [REG_NUM_WIDTH-1:0] req_register_number,
   input  logic [DATA_WIDTH-1:0]    req_write_data,
   output logic                     rsp_valid,
   output logic [DATA_WIDTH-1:0]    rsp_read_data,
   output logic [1:0]               rsp_access_status
);

`include "chiplet_control_register_bank_unit_assert.svh"

   localparam int DEPTH = CONTROL_WORD_COUNT + 6;
   localparam int IW    = $clog2(DEPTH);

   state_type              state_ff, state_in;
   decode_type             dec;
   logic [IW-1:0]          dec_index;
   decode_type             decode_ff;
   logic [IW-1:0]          index_ff;
   logic                   opcode_ff;
   logic [DATA_WIDTH-1:0]  wdata_ff;
   logic                   accept;
   logic [DATA_WIDTH-1:0]  old_value;
   logic                   mem_wr_en;
   logic [DATA_WIDTH-1:0]  new_value;
   logic [DATA_WIDTH-1:0]  result_data;
   access_status_type      result_status;
   logic                   rsp_valid_ff;
   logic [DATA_WIDTH-1:0]  rsp_data_ff;
   access_status_type      rsp_status_ff;

   crbu_decode #(
      .CONTROL_WORD_COUNT(CONTROL_WORD_COUNT)
   ) u_decode (
      .register_number(req_register_number),
      .decode         (dec),
      .entry_index    (dec_index)
   );

   crbu_mem #(
      .DEPTH(DEPTH)
   ) u_mem (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (accept),
      .rd_addr(dec_index),
      .rd_data(old_value),
      .wr_en  (mem_wr_en),
      .wr_addr(index_ff),
      .wr_data(new_value)
   );

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and handshake.
   always_comb begin
      state_in = state_ff;
      busy     = 1'b0;
      accept   = 1'b0;
      unique case (state_ff)
         STATE_IDLE: begin
            accept = start;
            if (start) begin
               state_in = STATE_EXEC;
            end
         end
         STATE_EXEC: begin
            busy     = 1'b1;
            state_in = STATE_IDLE;
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   // Request capture at the transfer.
   always_ff @(posedge clock) begin
      if (accept) begin
         decode_ff <= dec;
         index_ff  <= dec_index;
         opcode_ff <= req_opcode;
         wdata_ff  <= req_write_data;
      end
   end

   // Modify step: merge the old value with the write data.
   always_comb begin
      case (decode_ff.kind)
         KIND_SET:   new_value = old_value | wdata_ff;
         KIND_CLEAR: new_value = old_value & ~wdata_ff;
         default:    new_value = wdata_ff;
      endcase
   end

   assign mem_wr_en = busy && (opcode_ff == OPCODE_WRITE) &&
                      (decode_ff.plain_hit || decode_ff.alias_hit);

   // Result value and status.
   always_comb begin
      if (opcode_ff == OPCODE_WRITE) begin
         result_data   = '0;
         result_status = (decode_ff.plain_hit || decode_ff.alias_hit) ?
                         STATUS_OK : STATUS_UNIMPLEMENTED;
      end else if (decode_ff.plain_hit) begin
         result_data   = old_value;
         result_status = STATUS_OK;
      end else if (decode_ff.alias_hit) begin
         result_data   = ALL_ONES;
         result_status = STATUS_WRITE_ONLY;
      end else begin
         result_data   = ALL_ONES;
         result_status = STATUS_UNIMPLEMENTED;
      end
   end

   // Result register: one strobe per request.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= busy;
      end
   end

   always_ff @(posedge clock) begin
      if (busy) begin
         rsp_data_ff   <= result_data;
         rsp_status_ff <= result_status;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = rsp_data_ff;
   assign rsp_access_status = rsp_status_ff;

   // Checks on sequencing and result encoding.
   `CRBU_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `CRBU_ASSERT_NEXT(a_exec_result, clock, reset, busy, rsp_valid && !busy)
   `CRBU_ASSERT_NOW(a_write_in_exec, clock, reset, mem_wr_en,
                    busy && opcode_ff == OPCODE_WRITE)
   `CRBU_ASSERT_NOW(a_wonly_ones, clock, reset,
                    rsp_valid && rsp_access_status == STATUS_WRITE_ONLY,
                    rsp_read_data == ALL_ONES)

endmodule

@@ src/crbu_decode.sv @@
// ----------------------------------------------------------------------------
// crbu_decode
// Address decoder: maps a register number to a storage entry and tells
// whether it is a plain register, a set or clear alias, or unmapped.
// ----------------------------------------------------------------------------
module crbu_decode
   import crbu_pkg::*;
#(
   parameter int CONTROL_WORD_COUNT = 6
) (
   input  logic [REG_NUM_WIDTH-1:0]                   register_number,
   output decode_type                                 decode,
   output logic [$clog2(CONTROL_WORD_COUNT+6)-1:0]    entry_index
);

   localparam int IW = $clog2(CONTROL_WORD_COUNT + 6);

   // Entry layout: control words first, then the six single words.
   localparam logic [IW-1:0] IDX_CONF0   = IW'(CONTROL_WORD_COUNT);
   localparam logic [IW-1:0] IDX_CONF1   = IW'(CONTROL_WORD_COUNT + 1);
   localparam logic [IW-1:0] IDX_STATUS  = IW'(CONTROL_WORD_COUNT + 2);
   localparam logic [IW-1:0] IDX_MASK    = IW'(CONTROL_WORD_COUNT + 3);
   localparam logic [IW-1:0] IDX_PROTECT = IW'(CONTROL_WORD_COUNT + 4);
   localparam logic [IW-1:0] IDX_LOCK    = IW'(CONTROL_WORD_COUNT + 5);

   localparam logic [REG_NUM_WIDTH-1:0] CW_COUNT = REG_NUM_WIDTH'(CONTROL_WORD_COUNT);

   logic [REG_NUM_WIDTH-1:0] set_offset;
   logic [REG_NUM_WIDTH-1:0] clr_offset;

   assign set_offset = register_number - SET_ALIAS_BASE;
   assign clr_offset = register_number - CLR_ALIAS_BASE;

   // Plain control words and control aliases are ranges; the rest are fixed.
   always_comb begin
      decode.plain_hit = 1'b0;
      decode.alias_hit = 1'b0;
      decode.kind      = KIND_PLAIN;
      entry_index      = '0;
      if (register_number < CW_COUNT) begin
         decode.plain_hit = 1'b1;
         entry_index      = IW'(register_number);
      end else if (register_number >= SET_ALIAS_BASE && set_offset < CW_COUNT) begin
         decode.alias_hit = 1'b1;
         decode.kind      = KIND_SET;
         entry_index      = IW'(set_offset);
      end else if (register_number >= CLR_ALIAS_BASE && clr_offset < CW_COUNT) begin
         decode.alias_hit = 1'b1;
         decode.kind      = KIND_CLEAR;
         entry_index      = IW'(clr_offset);
      end else begin
         unique case (register_number)
            REG_CONF0: begin
               decode.plain_hit = 1'b1;
               entry_index      = IDX_CONF0;
            end
            REG_CONF1: begin
               decode.plain_hit = 1'b1;
               entry_index      = IDX_CONF1;
            end
            REG_STATUS: begin
               decode.plain_hit = 1'b1;
               entry_index      = IDX_STATUS;
            end
            REG_MASK: begin
               decode.plain_hit = 1'b1;
               entry_index      = IDX_MASK;
            end
            REG_PROTECT: begin
               decode.plain_hit = 1'b1;
               entry_index      = IDX_PROTECT;
            end
            REG_LOCK: begin
               decode.plain_hit = 1'b1;
               entry_index      = IDX_LOCK;
            end
            REG_CONF0_SET: begin
               decode.alias_hit = 1'b1;
               decode.kind      = KIND_SET;
               entry_index      = IDX_CONF0;
            end
            REG_CONF0_CLR: begin
               decode.alias_hit = 1'b1;
               decode.kind      = KIND_CLEAR;
               entry_index      = IDX_CONF0;
            end
            REG_CONF1_SET: begin
               decode.alias_hit = 1'b1;
               decode.kind      = KIND_SET;
               entry_index      = IDX_CONF1;
            end
            REG_CONF1_CLR: begin
               decode.alias_hit = 1'b1;
               decode.kind      = KIND_CLEAR;
               entry_index      = IDX_CONF1;
            end
            default: begin
               decode.plain_hit = 1'b0;
            end
         endcase
      end
   end

endmodule

@@ src/crbu_mem.sv @@
// ----------------------------------------------------------------------------
// crbu_mem
// Register storage: a small synchronous memory with one registered read
// port and one write port. A valid bit per entry makes entries that were
// never written since reset read as zero.
// ----------------------------------------------------------------------------
module crbu_mem
   import crbu_pkg::*;
#(
   parameter int DEPTH = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_WIDTH-1:0]    rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0]    wr_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0]      valid_ff;
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic                  rd_valid_ff;

   // Storage array and registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Valid bits are cleared by reset; the read samples the entry's bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the control register bank with set-bit and clear-bit
// aliases. A short table of directed accesses covers reset values, set and
// clear aliases, write-only reads and unmapped addresses; a long random run
// follows. Results are checked against the table, else against a local model.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import crbu_pkg::*;

   localparam int CW = 6;

   // Slots of the local copy of the bank: control words first, then the rest.
   localparam int NO_WORD      = -1;
   localparam int WORD_CONF0   = CW;
   localparam int WORD_CONF1   = CW + 1;
   localparam int WORD_STATUS  = CW + 2;
   localparam int WORD_MASK    = CW + 3;
   localparam int WORD_PROTECT = CW + 4;
   localparam int WORD_LOCK    = CW + 5;
   localparam int WORD_COUNT   = CW + 6;

   // Unmapped register numbers used by the directed accesses.
   localparam logic [REG_NUM_WIDTH-1:0] REG_PAST_CONTROL = REG_NUM_WIDTH'(CW);
   localparam logic [REG_NUM_WIDTH-1:0] REG_PAST_SET     = REG_NUM_WIDTH'(SET_ALIAS_BASE + CW);
   localparam logic [REG_NUM_WIDTH-1:0] REG_BELOW_PROTECT = 10'h3FD;

   localparam int RANDOM_ITEMS = 1650;
   localparam int CALM_ITEMS   = 200;
   localparam int STALL_LIMIT  = 1000;
   localparam int MAX_REPORTS  = 10;

   typedef struct {
      logic                     opcode;
      logic [REG_NUM_WIDTH-1:0] reg_num;
      logic [DATA_WIDTH-1:0]    wdata;
      bit                       known;
      logic [DATA_WIDTH-1:0]    rdata;
      access_status_type        status;
   } access_row_type;

   typedef struct {
      logic [DATA_WIDTH-1:0] rdata;
      access_status_type     status;
   } bank_result_type;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic                     req_opcode;
   logic [REG_NUM_WIDTH-1:0] req_register_number;
   logic [DATA_WIDTH-1:0]    req_write_data;
   logic                     rsp_valid;
   logic [DATA_WIDTH-1:0]    rsp_read_data;
   logic [1:0]               rsp_access_status;

   logic [DATA_WIDTH-1:0]    bank_words [WORD_COUNT];
   bank_result_type          pending_results [$];
   access_row_type           directed_rows [$];
   logic [REG_NUM_WIDTH-1:0] mapped_regs [$];

   int error_count;
   int stall_cycles;
   int n_reads;
   int n_writes;
   int n_ok;
   int n_write_only;
   int n_unimpl;

   chiplet_control_register_bank_unit #(
      .CONTROL_WORD_COUNT(CW)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_opcode          (req_opcode),
      .req_register_number (req_register_number),
      .req_write_data      (req_write_data),
      .rsp_valid           (rsp_valid),
      .rsp_read_data       (rsp_read_data),
      .rsp_access_status   (rsp_access_status)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic note_error(input string msg);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("ERROR at %0t: %s", $realtime, msg);
      end
   endtask

   // Decodes one access, updates the local bank copy and returns the result.
   function automatic void bank_access(
      input  logic                     opcode,
      input  logic [REG_NUM_WIDTH-1:0] reg_num,
      input  logic [DATA_WIDTH-1:0]    wdata,
      output logic [DATA_WIDTH-1:0]    rdata,
      output access_status_type        status
   );
      int             slot;
      write_kind_type kind;
      slot = NO_WORD;
      kind = KIND_PLAIN;

      // Plain registers first.
      if (reg_num < CW) begin
         slot = int'(reg_num);
      end else begin
         case (reg_num)
            REG_CONF0:   slot = WORD_CONF0;
            REG_CONF1:   slot = WORD_CONF1;
            REG_STATUS:  slot = WORD_STATUS;
            REG_MASK:    slot = WORD_MASK;
            REG_PROTECT: slot = WORD_PROTECT;
            REG_LOCK:    slot = WORD_LOCK;
            default:     slot = NO_WORD;
         endcase
      end

      // Then the set-bit and clear-bit aliases.
      if (slot == NO_WORD) begin
         if (reg_num >= SET_ALIAS_BASE && reg_num < SET_ALIAS_BASE + CW) begin
            slot = int'(reg_num - SET_ALIAS_BASE);
            kind = KIND_SET;
         end else if (reg_num >= CLR_ALIAS_BASE && reg_num < CLR_ALIAS_BASE + CW) begin
            slot = int'(reg_num - CLR_ALIAS_BASE);
            kind = KIND_CLEAR;
         end else begin
            case (reg_num)
               REG_CONF0_SET: begin slot = WORD_CONF0; kind = KIND_SET;   end
               REG_CONF0_CLR: begin slot = WORD_CONF0; kind = KIND_CLEAR; end
               REG_CONF1_SET: begin slot = WORD_CONF1; kind = KIND_SET;   end
               REG_CONF1_CLR: begin slot = WORD_CONF1; kind = KIND_CLEAR; end
               default: ;
            endcase
         end
      end

      if (opcode == OPCODE_WRITE) begin
         n_writes++;
         rdata = '0;
         if (slot == NO_WORD) begin
            status = STATUS_UNIMPLEMENTED;
         end else begin
            status = STATUS_OK;
            case (kind)
               KIND_PLAIN: bank_words[slot] = wdata;
               KIND_SET:   bank_words[slot] = bank_words[slot] | wdata;
               default:    bank_words[slot] = bank_words[slot] & ~wdata;
            endcase
         end
      end else begin
         n_reads++;
         if (slot == NO_WORD) begin
            rdata  = ALL_ONES;
            status = STATUS_UNIMPLEMENTED;
         end else if (kind != KIND_PLAIN) begin
            rdata  = ALL_ONES;
            status = STATUS_WRITE_ONLY;
         end else begin
            rdata  = bank_words[slot];
            status = STATUS_OK;
         end
      end

      case (status)
         STATUS_OK:         n_ok++;
         STATUS_WRITE_ONLY: n_write_only++;
         default:           n_unimpl++;
      endcase
   endfunction

   // Presents one access after an optional gap and waits for its transfer.
   // Called at a rising edge; returns at the edge of the transfer.
   task automatic issue_access(input access_row_type row, input int gap);
      bit                    taken;
      logic [DATA_WIDTH-1:0] rdata;
      access_status_type     status;
      bank_result_type       want;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start               <= 1'b1;
      req_opcode          <= row.opcode;
      req_register_number <= row.reg_num;
      req_write_data      <= row.wdata;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);

      // The model always runs so that its state follows the bank.
      bank_access(row.opcode, row.reg_num, row.wdata, rdata, status);
      if (row.known) begin
         want.rdata  = row.rdata;
         want.status = row.status;
      end else begin
         want.rdata  = rdata;
         want.status = status;
      end
      pending_results.push_back(want);
   endtask

   task automatic add_row(
      input logic                     opcode,
      input logic [REG_NUM_WIDTH-1:0] reg_num,
      input logic [DATA_WIDTH-1:0]    wdata,
      input bit                       known,
      input logic [DATA_WIDTH-1:0]    rdata,
      input access_status_type        status
   );
      access_row_type row;
      row.opcode  = opcode;
      row.reg_num = reg_num;
      row.wdata   = wdata;
      row.known   = known;
      row.rdata   = rdata;
      row.status  = status;
      directed_rows.push_back(row);
   endtask

   // Result checker: every strobed result is matched with the oldest expectation.
   always @(negedge clock) begin : check_result
      bank_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            note_error($sformatf("result with none expected: data %h status %0d",
                                 rsp_read_data, rsp_access_status));
         end else begin
            want = pending_results.pop_front();
            if (rsp_read_data !== want.rdata) begin
               note_error($sformatf("read_data expected %h got %h",
                                    want.rdata, rsp_read_data));
            end
            if (rsp_access_status !== want.status) begin
               note_error($sformatf("access_status expected %0d got %0d",
                                    want.status, rsp_access_status));
            end
         end
      end
   end

   // Watchdog on cycles in which no transfer of either kind happens.
   always @(negedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", stall_cycles);
            $display("chiplet_control_register_bank_unit test failed");
            $finish;
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      access_row_type row;
      int             gap;
      int             pick;
      start               <= 1'b0;
      reset               <= 1'b1;
      req_opcode          <= OPCODE_READ;
      req_register_number <= '0;
      req_write_data      <= '0;
      error_count  = 0;
      stall_cycles = 0;
      n_reads      = 0;
      n_writes     = 0;
      n_ok         = 0;
      n_write_only = 0;
      n_unimpl     = 0;
      foreach (bank_words[i]) bank_words[i] = '0;

      for (int i = 0; i < CW; i++) begin
         mapped_regs.push_back(REG_NUM_WIDTH'(i));
         mapped_regs.push_back(REG_NUM_WIDTH'(SET_ALIAS_BASE + i));
         mapped_regs.push_back(REG_NUM_WIDTH'(CLR_ALIAS_BASE + i));
      end
      mapped_regs.push_back(REG_CONF0);
      mapped_regs.push_back(REG_CONF0_SET);
      mapped_regs.push_back(REG_CONF0_CLR);
      mapped_regs.push_back(REG_CONF1);
      mapped_regs.push_back(REG_CONF1_SET);
      mapped_regs.push_back(REG_CONF1_CLR);
      mapped_regs.push_back(REG_STATUS);
      mapped_regs.push_back(REG_MASK);
      mapped_regs.push_back(REG_PROTECT);
      mapped_regs.push_back(REG_LOCK);

      // Directed accesses; a zero known flag means the model decides.
      add_row(OPCODE_READ,  '0,                 '0, 1'b1, '0, STATUS_OK);
      add_row(OPCODE_READ,  REG_LOCK,           '0, 1'b1, '0, STATUS_OK);
      add_row(OPCODE_WRITE, '0,                 ALL_ONES, 1'b1, '0, STATUS_OK);
      add_row(OPCODE_READ,  '0,                 '0, 1'b1, ALL_ONES, STATUS_OK);
      add_row(OPCODE_WRITE, CLR_ALIAS_BASE,     64'h0000_0000_FFFF_FFFF, 1'b1, '0, STATUS_OK);
      add_row(OPCODE_WRITE, SET_ALIAS_BASE,     64'h0000_0000_0000_0001, 1'b1, '0, STATUS_OK);
      add_row(OPCODE_READ,  '0,                 '0, 1'b0, '0, STATUS_OK);
      add_row(OPCODE_READ,  SET_ALIAS_BASE,     '0, 1'b1, ALL_ONES, STATUS_WRITE_ONLY);
      add_row(OPCODE_READ,  REG_NUM_WIDTH'(CLR_ALIAS_BASE + CW - 1), '0, 1'b1, ALL_ONES,
              STATUS_WRITE_ONLY);
      add_row(OPCODE_WRITE, REG_NUM_WIDTH'(CW - 1), 64'h8000_0000_0000_0001, 1'b1, '0,
              STATUS_OK);
      add_row(OPCODE_READ,  REG_NUM_WIDTH'(CW - 1), '0, 1'b0, '0, STATUS_OK);
      add_row(OPCODE_WRITE, REG_CONF0_SET,      64'hA5A5_A5A5_A5A5_A5A5, 1'b1, '0, STATUS_OK);
      add_row(OPCODE_WRITE, REG_CONF0_CLR,      64'h00FF_00FF_00FF_00FF, 1'b1, '0, STATUS_OK);
      add_row(OPCODE_READ,  REG_CONF0,          '0, 1'b0, '0, STATUS_OK);
      add_row(OPCODE_WRITE, REG_CONF1_SET,      ALL_ONES, 1'b1, '0, STATUS_OK);
      add_row(OPCODE_WRITE, REG_CONF1_CLR,      64'h8000_0000_0000_0000, 1'b1, '0, STATUS_OK);
      add_row(OPCODE_READ,  REG_CONF1_SET,      '0, 1'b1, ALL_ONES, STATUS_WRITE_ONLY);
      add_row(OPCODE_READ,  REG_CONF1,          '0, 1'b0, '0, STATUS_OK);
      add_row(OPCODE_WRITE, REG_STATUS,         64'h0123_4567_89AB_CDEF, 1'b1, '0, STATUS_OK);
      add_row(OPCODE_WRITE, REG_MASK,           64'hFEDC_BA98_7654_3210, 1'b1, '0, STATUS_OK);
      add_row(OPCODE_WRITE, REG_PROTECT,        64'h0000_0000_0000_0001, 1'b1, '0, STATUS_OK);
      add_row(OPCODE_WRITE, REG_LOCK,           ALL_ONES, 1'b1, '0, STATUS_OK);
      add_row(OPCODE_READ,  REG_LOCK,           '0, 1'b1, ALL_ONES, STATUS_OK);
      add_row(OPCODE_READ,  REG_PAST_CONTROL,   '0, 1'b1, ALL_ONES, STATUS_UNIMPLEMENTED);
      add_row(OPCODE_WRITE, REG_BELOW_PROTECT,  ALL_ONES, 1'b1, '0, STATUS_UNIMPLEMENTED);
      add_row(OPCODE_READ,  REG_PAST_SET,       ALL_ONES, 1'b1, ALL_ONES, STATUS_UNIMPLEMENTED);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 5) : 0;
         issue_access(directed_rows[i], gap);
      end

      // Random accesses, mostly to mapped registers and aliases.
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         row.known  = 1'b0;
         row.rdata  = '0;
         row.status = STATUS_OK;
         row.opcode = 1'($urandom_range(0, 1));
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            row.reg_num = mapped_regs[$urandom_range(0, mapped_regs.size() - 1)];
         end else if (pick == 7) begin
            case ($urandom_range(0, 3))
               0:       row.reg_num = REG_PAST_CONTROL;
               1:       row.reg_num = REG_PAST_SET;
               2:       row.reg_num = REG_NUM_WIDTH'(CLR_ALIAS_BASE + CW);
               default: row.reg_num = REG_BELOW_PROTECT;
            endcase
         end else begin
            row.reg_num = REG_NUM_WIDTH'($urandom_range(0, (1 << REG_NUM_WIDTH) - 1));
         end
         case ($urandom_range(0, 7))
            0:       row.wdata = '0;
            1:       row.wdata = ALL_ONES;
            2:       row.wdata = 64'd1 << $urandom_range(0, DATA_WIDTH - 1);
            default: row.wdata = {$urandom, $urandom};
         endcase

         // One pause lets every outstanding result come back first.
         if (k == RANDOM_ITEMS / 2) begin
            start <= 1'b0;
            do @(posedge clock); while (pending_results.size() != 0);
         end

         if (k < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
         end else begin
            gap = 0;
         end
         issue_access(row, gap);
      end

      // Drain the outstanding results, then a few quiet cycles.
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Covered %0d reads and %0d writes to the bank and its aliases.",
               n_reads, n_writes);
      $display("Results seen: %0d ok, %0d write-only, %0d unimplemented; %0d errors.",
               n_ok, n_write_only, n_unimpl, error_count);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("chiplet_control_register_bank_unit test passed");
      end else begin
         $display("chiplet_control_register_bank_unit test failed");
      end
      $finish;
   end

endmodule
